// ===== src/tcogr_pkg.sv =====
// Shared constants, codes and types of the three-channel offset and gain ranging unit.
package tcogr_pkg;

  localparam int OFFSET_WIDTH_DEF = 16;
  localparam int NUM_CH           = 3;
  localparam int QDEPTH           = 2;
  localparam int CFG_AW           = 4;
  localparam int CFG_DW           = 32;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_AC_LOW    = 2'd0;
  localparam logic [1:0] REG_DC_HIGH   = 2'd1;
  localparam logic [1:0] REG_OFF_INIT  = 2'd2;
  localparam logic [1:0] REG_OFF_LIMIT = 2'd3;

  // Status codes of the final word.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Gain codes.
  localparam logic [1:0] GAIN_X16  = 2'd0;
  localparam logic [1:0] GAIN_X128 = 2'd1;
  localparam logic [1:0] GAIN_X256 = 2'd2;
  localparam logic [1:0] GAIN_BAD  = 2'd3;

  localparam logic [15:0] PROBE_OFFSET = 16'd170;
  localparam logic [15:0] PROBE_DC_MAX = 16'd2047;
  localparam logic [15:0] OFFSET_STEP  = 16'd10;
  localparam logic [15:0] OFFSET_RST   = 16'd170;

  localparam logic [15:0] AC_LOW_RST    = 16'd100;
  localparam logic [15:0] DC_HIGH_RST   = 16'd60000;
  localparam logic [15:0] OFF_INIT_RST  = 16'd170;
  localparam logic [15:0] OFF_LIMIT_RST = 16'd4095;

  typedef struct packed {
    logic [15:0] ac_low;
    logic [15:0] dc_high;
    logic [15:0] off_init;
    logic [15:0] off_limit;
  } cfg_t;

  // Classification of one measurement set, as handed from front to back.
  typedef struct packed {
    logic [NUM_CH-1:0] ac_weak;
    logic [NUM_CH-1:0] dc_strong;
    logic              probe_dc;
    logic              conflict;
  } class_t;

endpackage

// ===== src/tcogr_if.sv =====
// Valid/ready channel interfaces for measurement words and result words.
interface tcogr_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] dc_red;
  logic [15:0] ac_red;
  logic [15:0] dc_mid;
  logic [15:0] ac_mid;
  logic [15:0] dc_ir;
  logic [15:0] ac_ir;

  modport source (output valid, dc_red, ac_red, dc_mid, ac_mid, dc_ir, ac_ir, input ready);
  modport sink (input valid, dc_red, ac_red, dc_mid, ac_mid, dc_ir, ac_ir, output ready);
endinterface

interface tcogr_out_if;
  logic        valid;
  logic        ready;
  logic        dac_write;
  logic [1:0]  dac_channel;
  logic [15:0] dac_value;
  logic [1:0]  status;
  logic [1:0]  gain_red;
  logic [1:0]  gain_mid;
  logic [1:0]  gain_ir;
  logic        last;

  modport source (output valid, dac_write, dac_channel, dac_value, status, gain_red,
                  gain_mid, gain_ir, last, input ready);
  modport sink (input valid, dac_write, dac_channel, dac_value, status, gain_red,
                gain_mid, gain_ir, last, output ready);
endinterface

// ===== src/three_channel_offset_gain_ranging_unit.sv =====
// Top level of the three-channel offset and gain ranging unit.
//
//   Channel   Direction  Handshake                     Contents
//   in_word   sink       valid/ready                   DC and AC level of three channels
//   out_word  source     valid/ready                   DAC offset writes, then one status word
//   cfg_*     slave      APB setup+access, pready = 1  four 16-bit threshold/bound registers
//
// A measurement word is classified on entry and queued (two entries) for the ranging
// sequencer. The sequencer walks six steps, one per rule and channel, and then emits
// the status word; the next queued word may be picked up alongside that status step.
// Rule steps that do not apply pass without a write, and a disconnect or out-of-range
// decision made as the word is picked up jumps straight to the status word. A stalled
// result side holds the sequencer on its current step while the input side keeps
// filling the queue. Reset is synchronous and active low: offsets return to 170, gains
// to x16, registers to their defaults.
module three_channel_offset_gain_ranging_unit #(
  parameter int OFFSET_WIDTH = tcogr_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tcogr_in_if.sink                      in_word,
  tcogr_out_if.source                   out_word,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tcogr_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [tcogr_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [tcogr_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                          cfg_pready
);
  import tcogr_pkg::*;

  // Register contents, shared by the classifier and the sequencer. The user must change them
  // only while the unit is idle, so a queued classification never goes stale; the unit does not enforce it.
  cfg_t   cfg;
  logic   q_valid;
  logic   q_pop;
  class_t q_class;

  tcogr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Front end: threshold compares and the disconnect/conflict flags are worked out as
  // the word is accepted, so the queue carries only a handful of flag bits.
  tcogr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_word (in_word),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_class (q_class)
  );

  // Back end: owns the offset and gain state and the result register. The probe check
  // needs the red offset as left by the previous word, so it is made when a queued
  // word is picked up rather than in the front end.
  tcogr_back #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_class  (q_class),
    .out_word (out_word)
  );

endmodule

// ===== src/tcogr_cfg.sv =====
// APB-style register file holding the thresholds and offset bounds.
module tcogr_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcogr_pkg::CFG_AW-1:0]  paddr,
  input  logic [tcogr_pkg::CFG_DW-1:0]  pwdata,
  output logic [tcogr_pkg::CFG_DW-1:0]  prdata,
  output logic                          pready,
  output tcogr_pkg::cfg_t               cfg
);
  import tcogr_pkg::*;

  cfg_t       cfg_r;
  logic [1:0] idx;
  logic       wr_en;

  assign idx    = paddr[CFG_AW-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ac_low    <= AC_LOW_RST;
      cfg_r.dc_high   <= DC_HIGH_RST;
      cfg_r.off_init  <= OFF_INIT_RST;
      cfg_r.off_limit <= OFF_LIMIT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_AC_LOW:    cfg_r.ac_low    <= pwdata[15:0];
        REG_DC_HIGH:   cfg_r.dc_high   <= pwdata[15:0];
        REG_OFF_INIT:  cfg_r.off_init  <= pwdata[15:0];
        REG_OFF_LIMIT: cfg_r.off_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_AC_LOW:    prdata = CFG_DW'(cfg_r.ac_low);
      REG_DC_HIGH:   prdata = CFG_DW'(cfg_r.dc_high);
      REG_OFF_INIT:  prdata = CFG_DW'(cfg_r.off_init);
      REG_OFF_LIMIT: prdata = CFG_DW'(cfg_r.off_limit);
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== src/tcogr_front.sv =====
// Front end: accepts measurement words, classifies them and queues the result.
module tcogr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  tcogr_pkg::cfg_t   cfg,
  tcogr_in_if.sink          in_word,
  output logic              q_valid,
  input  logic              q_pop,
  output tcogr_pkg::class_t q_class
);
  import tcogr_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QDEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QDEPTH);

  class_t          slot_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  class_t          cls;
  logic            push;
  logic            pop;

  always_comb begin
    cls.ac_weak[0]   = in_word.ac_red < cfg.ac_low;
    cls.ac_weak[1]   = in_word.ac_mid < cfg.ac_low;
    cls.ac_weak[2]   = in_word.ac_ir  < cfg.ac_low;
    cls.dc_strong[0] = in_word.dc_red > cfg.dc_high;
    cls.dc_strong[1] = in_word.dc_mid > cfg.dc_high;
    cls.dc_strong[2] = in_word.dc_ir  > cfg.dc_high;
    cls.probe_dc     = in_word.dc_red > PROBE_DC_MAX;
    cls.conflict     = |(cls.ac_weak & cls.dc_strong);
  end

  assign in_word.ready = count_r != CNT_FULL;
  assign push          = in_word.valid && in_word.ready;
  assign q_valid       = count_r != '0;
  assign pop           = q_pop && q_valid;
  assign q_class       = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL) else $error("queue count beyond depth");
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + CW'(1)) else $error("push lost");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0) else $error("pop from empty queue");
`endif

endmodule

// ===== src/tcogr_back.sv =====
// Back end: per-channel ranging sequencer, offset/gain state and result register.
module tcogr_back #(
  parameter int OFFSET_WIDTH = tcogr_pkg::OFFSET_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tcogr_pkg::cfg_t   cfg,
  input  logic              q_valid,
  output logic              q_pop,
  input  tcogr_pkg::class_t q_class,
  tcogr_out_if.source       out_word
);
  import tcogr_pkg::*;

  localparam int OW = OFFSET_WIDTH;
  localparam logic [16:0]   OFF_MAX17  = 17'((1 << OW) - 1);
  localparam logic [OW-1:0] OFF_RESET  = OW'(OFFSET_RST);
  localparam logic [2:0]    STEP_FIRST = 3'd0;
  localparam logic [2:0]    STEP_STATUS = 3'd6;

  logic [OW-1:0] off_r    [NUM_CH];
  logic [OW-1:0] off_nxt  [NUM_CH];
  logic [1:0]    gain_r   [NUM_CH];
  logic [1:0]    gain_nxt [NUM_CH];

  logic          busy_r, busy_nxt;
  logic [2:0]    step_r, step_nxt;
  logic [1:0]    st_r, st_nxt;
  class_t        cls_r, cls_nxt;

  logic          out_valid_r;
  logic          out_dac_write_r;
  logic [1:0]    out_dac_channel_r;
  logic [15:0]   out_dac_value_r;
  logic [1:0]    out_status_r;
  logic [1:0]    out_gain_red_r, out_gain_mid_r, out_gain_ir_r;
  logic          out_last_r;

  logic          can_out;
  logic [1:0]    ch;
  logic          flag;
  logic [15:0]   cur_off16;
  logic [16:0]   raise_sum;
  logic [OW-1:0] raised, lowered, init_sat, limit_sat;
  logic          emit, emit_wr, emit_last;
  logic [1:0]    emit_st;
  logic [15:0]   emit_val;
  logic [1:0]    emit_ch;
  logic          take;

  assign can_out   = !out_valid_r || out_word.ready;
  assign ch        = (step_r == STEP_STATUS) ? 2'd0 : step_r[2:1];
  assign flag      = step_r[0] ? cls_r.dc_strong[ch] : cls_r.ac_weak[ch];
  assign cur_off16 = 16'(off_r[ch]);
  assign raise_sum = {1'b0, cur_off16} + {1'b0, OFFSET_STEP};
  assign raised    = (raise_sum > OFF_MAX17) ? OW'(OFF_MAX17) : OW'(raise_sum);
  assign lowered   = (cur_off16 >= OFFSET_STEP) ? OW'(cur_off16 - OFFSET_STEP) : '0;
  assign init_sat  = ({1'b0, cfg.off_init} > OFF_MAX17) ? OW'(OFF_MAX17) : OW'(cfg.off_init);
  assign limit_sat = ({1'b0, cfg.off_limit} > OFF_MAX17) ? OW'(OFF_MAX17)
                                                          : OW'(cfg.off_limit);

  always_comb begin
    off_nxt   = off_r;
    gain_nxt  = gain_r;
    busy_nxt  = busy_r;
    step_nxt  = step_r;
    st_nxt    = st_r;
    cls_nxt   = cls_r;
    emit      = 1'b0;
    emit_wr   = 1'b0;
    emit_last = 1'b0;
    emit_st   = ST_OK;
    take      = 1'b0;

    if (busy_r && can_out) begin
      if (step_r == STEP_STATUS) begin
        emit      = 1'b1;
        emit_st   = st_r;
        emit_last = 1'b1;
        busy_nxt  = 1'b0;
      end else if (flag) begin
        if (!step_r[0]) begin
          // Weak AC: raise the offset, or once at the limit step the gain up.
          if (cur_off16 < cfg.off_limit) begin
            off_nxt[ch] = raised;
            emit_wr     = 1'b1;
          end else begin
            case (gain_r[ch])
              GAIN_X16: begin
                gain_nxt[ch] = GAIN_X128;
                off_nxt[ch]  = init_sat;
                emit_wr      = 1'b1;
              end
              GAIN_X128: begin
                gain_nxt[ch] = GAIN_X256;
                off_nxt[ch]  = init_sat;
                emit_wr      = 1'b1;
              end
              GAIN_X256: ;
              default: gain_nxt[ch] = GAIN_X16;
            endcase
          end
        end else begin
          // Strong DC: lower the offset, or once at the floor step the gain down.
          if (cur_off16 > cfg.off_init) begin
            off_nxt[ch] = lowered;
            emit_wr     = 1'b1;
          end else begin
            case (gain_r[ch])
              GAIN_X16: ;
              GAIN_X128: begin
                gain_nxt[ch] = GAIN_X16;
                off_nxt[ch]  = limit_sat;
                emit_wr      = 1'b1;
              end
              GAIN_X256: begin
                gain_nxt[ch] = GAIN_X128;
                off_nxt[ch]  = limit_sat;
                emit_wr      = 1'b1;
              end
              default: gain_nxt[ch] = GAIN_X16;
            endcase
          end
        end
        if (emit_wr) begin
          emit     = 1'b1;
          step_nxt = step_r + 3'd1;
        end else begin
          st_nxt   = ST_RANGE;
          step_nxt = STEP_STATUS;
        end
      end else begin
        step_nxt = step_r + 3'd1;
      end
    end

    // The status step changes no state, so the next set may be picked up alongside it.
    if (q_valid && (!busy_r || (can_out && step_r == STEP_STATUS))) begin
      take     = 1'b1;
      busy_nxt = 1'b1;
      cls_nxt  = q_class;
      if (16'(off_r[0]) == PROBE_OFFSET && q_class.probe_dc) begin
        st_nxt   = ST_PROBE;
        step_nxt = STEP_STATUS;
      end else if (q_class.conflict) begin
        st_nxt   = ST_RANGE;
        step_nxt = STEP_STATUS;
      end else begin
        st_nxt   = ST_OK;
        step_nxt = STEP_FIRST;
      end
    end

    emit_val = emit_wr ? 16'(off_nxt[ch]) : '0;
    emit_ch  = emit_wr ? ch : 2'd0;
  end

  assign q_pop = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= STEP_STATUS;
      st_r   <= ST_OK;
      for (int i = 0; i < NUM_CH; i++) begin
        off_r[i]  <= OFF_RESET;
        gain_r[i] <= GAIN_X16;
      end
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      st_r   <= st_nxt;
      off_r  <= off_nxt;
      gain_r <= gain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cls_r <= cls_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_dac_write_r   <= emit_wr;
      out_dac_channel_r <= emit_ch;
      out_dac_value_r   <= emit_val;
      out_status_r      <= emit_st;
      out_gain_red_r    <= gain_nxt[0];
      out_gain_mid_r    <= gain_nxt[1];
      out_gain_ir_r     <= gain_nxt[2];
      out_last_r        <= emit_last;
    end
  end

  assign out_word.valid       = out_valid_r;
  assign out_word.dac_write   = out_dac_write_r;
  assign out_word.dac_channel = out_dac_channel_r;
  assign out_word.dac_value   = out_dac_value_r;
  assign out_word.status      = out_status_r;
  assign out_word.gain_red    = out_gain_red_r;
  assign out_word.gain_mid    = out_gain_mid_r;
  assign out_word.gain_ir     = out_gain_ir_r;
  assign out_word.last        = out_last_r;

`ifndef SYNTHESIS
  a_gain_legal: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r[0] != GAIN_BAD && gain_r[1] != GAIN_BAD && gain_r[2] != GAIN_BAD)
    else $error("gain code left in invalid state");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_STATUS) else $error("sequencer step out of range");
  a_write_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_dac_write_r |-> !out_last_r && out_status_r == ST_OK)
    else $error("DAC write word marked as final");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> !busy_r || step_r == STEP_STATUS) else $error("new set taken mid-sequence");
`endif

endmodule
